>>> hdl/integer_to_ascii_radix_converter_assert.svh
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter assertion macros
// Shared concurrent assertion forms for the converter modules.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_CONVERTER_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_CONVERTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2ARC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/i2arc_pkg.sv
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package i2arc_pkg;

  localparam int unsigned POINTER_MIN_DIGITS = 12;

  localparam int unsigned VALUE_W   = 64;
  localparam int unsigned OPCODE_W  = 3;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned IN_DATA_W = 72;
  localparam int unsigned SHIFT_W   = 80;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned STEP_W    = 4;

  localparam logic [OPCODE_W-1:0] OPC_DEC       = 3'd0;
  localparam logic [OPCODE_W-1:0] OPC_BIN       = 3'd1;
  localparam logic [OPCODE_W-1:0] OPC_OCT       = 3'd2;
  localparam logic [OPCODE_W-1:0] OPC_HEX_LOWER = 3'd3;
  localparam logic [OPCODE_W-1:0] OPC_HEX_UPPER = 3'd4;
  localparam logic [OPCODE_W-1:0] OPC_PTR_LOWER = 3'd5;
  localparam logic [OPCODE_W-1:0] OPC_PTR_UPPER = 3'd6;

  localparam logic [CNT_W-1:0] DEC_DIGITS = 7'd20;
  localparam logic [CNT_W-1:0] BIN_DIGITS = 7'd64;
  localparam logic [CNT_W-1:0] OCT_DIGITS = 7'd22;
  localparam logic [CNT_W-1:0] HEX_DIGITS = 7'd16;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_HEX = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    CHAR_ZERO  = 2'd0,
    CHAR_X     = 2'd1,
    CHAR_DIGIT = 2'd2
  } char_sel_e;

  typedef struct packed {
    logic      load;
    logic      conv;
    logic      shift;
    logic      push;
    char_sel_e sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic top_zero;
    logic above_min;
    logic cnt_one;
    logic is_dec;
    logic is_ptr;
    logic out_free;
  } dp_status_t;

endpackage

>>> hdl/integer_to_ascii_radix_converter.sv
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter
// Turns a 64-bit unsigned value into decimal, binary, octal, hex or pointer
// text, one ASCII character per output item, most significant first.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid / s_axis_tready  value, opcode
// m_axis    out        m_axis_tvalid / m_axis_tready  character, last
//
// An item is taken only while the controller is idle. Decimal uses a binary to
// BCD pass, four bits per cycle; other radixes go straight past it. Leading
// zero digits are then skipped at one per cycle, and characters follow at one
// per cycle while the output is free. A stalled output holds the character
// sequencer; reset needs no clearing.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_converter #(
  parameter int unsigned POINTER_MIN_DIGITS = i2arc_pkg::POINTER_MIN_DIGITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [i2arc_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // value[63:0], opcode[66:64]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [i2arc_pkg::CHAR_W-1:0]      m_axis_tdata,   // character[7:0]
  output logic                              m_axis_tlast
);

  i2arc_pkg::dp_cmd_t    cmd;
  i2arc_pkg::dp_status_t status;

  i2arc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2arc_dp #(
    .POINTER_MIN_DIGITS (POINTER_MIN_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_value_i  (s_axis_tdata[i2arc_pkg::VALUE_W-1:0]),
    .in_opcode_i (s_axis_tdata[i2arc_pkg::VALUE_W +: i2arc_pkg::OPCODE_W]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

>>> hdl/i2arc_dp.sv
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter datapath
// Digit shift register, binary to BCD conversion and output register.
// ----------------------------------------------------------------------------
module i2arc_dp #(
  parameter int unsigned POINTER_MIN_DIGITS = i2arc_pkg::POINTER_MIN_DIGITS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [i2arc_pkg::VALUE_W-1:0]     in_value_i,
  input  logic [i2arc_pkg::OPCODE_W-1:0]    in_opcode_i,
  input  i2arc_pkg::dp_cmd_t                cmd_i,
  output i2arc_pkg::dp_status_t             status_o,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [i2arc_pkg::CHAR_W-1:0]      out_char_o,
  output logic                              out_last_o
);

  localparam logic [i2arc_pkg::CHAR_W-1:0] ASCII_ZERO    = 8'h30;
  localparam logic [i2arc_pkg::CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
  localparam logic [i2arc_pkg::CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
  localparam logic [i2arc_pkg::CHAR_W-1:0] ASCII_LOWER_X = 8'h78;
  localparam logic [i2arc_pkg::CHAR_W-1:0] ASCII_UPPER_X = 8'h58;
  localparam logic [i2arc_pkg::CNT_W-1:0]  PTR_MIN = i2arc_pkg::CNT_W'(POINTER_MIN_DIGITS);
  localparam logic [i2arc_pkg::CNT_W-1:0]  ONE_DIGIT = 7'd1;
  localparam logic [i2arc_pkg::STEP_W-1:0] LAST_STEP = 4'hF;

  localparam int unsigned BCD_DIGITS = i2arc_pkg::SHIFT_W / 4;
  localparam int unsigned PAIR_W     = i2arc_pkg::SHIFT_W + i2arc_pkg::VALUE_W;

  logic [i2arc_pkg::SHIFT_W-1:0]  sh_q, sh_d;
  logic [i2arc_pkg::VALUE_W-1:0]  bin_q, bin_d;
  logic [i2arc_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  logic [i2arc_pkg::STEP_W-1:0]   step_q, step_d;
  i2arc_pkg::radix_e              radix_q, radix_d;
  logic                           upper_q, upper_d;
  logic                           ptr_q, ptr_d;
  logic                           out_valid_q;
  logic [i2arc_pkg::CHAR_W-1:0]   out_char_q, out_char_d;
  logic                           out_last_q;
  logic [3:0]                     digit;
  logic [i2arc_pkg::CHAR_W-1:0]   digit_char;
  logic [PAIR_W-1:0]              dabble;

  // Four shift-and-adjust steps of the double dabble conversion.
  function automatic logic [PAIR_W-1:0] dabble4(
    input logic [i2arc_pkg::SHIFT_W-1:0] bcd,
    input logic [i2arc_pkg::VALUE_W-1:0] bin
  );
    logic [i2arc_pkg::SHIFT_W-1:0] b;
    logic [i2arc_pkg::VALUE_W-1:0] v;
    b = bcd;
    v = bin;
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
        if (b[4*k +: 4] >= 4'd5) begin
          b[4*k +: 4] = b[4*k +: 4] + 4'd3;
        end
      end
      {b, v} = {b[i2arc_pkg::SHIFT_W-2:0], v, 1'b0};
    end
    return {b, v};
  endfunction

  assign dabble = dabble4(sh_q, bin_q);

  always_comb begin
    unique case (radix_q)
      i2arc_pkg::RADIX_BIN: digit = {3'b000, sh_q[i2arc_pkg::SHIFT_W-1]};
      i2arc_pkg::RADIX_OCT: digit = {1'b0, sh_q[i2arc_pkg::SHIFT_W-1 -: 3]};
      default:              digit = sh_q[i2arc_pkg::SHIFT_W-1 -: 4];
    endcase
  end

  always_comb begin
    if (digit < 4'd10) begin
      digit_char = ASCII_ZERO + {4'b0000, digit};
    end else begin
      digit_char = (upper_q ? ASCII_UPPER_A : ASCII_LOWER_A) + {4'b0000, digit} - 8'd10;
    end
  end

  always_comb begin
    sh_d    = sh_q;
    bin_d   = bin_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    radix_d = radix_q;
    upper_d = upper_q;
    ptr_d   = ptr_q;
    if (cmd_i.load) begin
      step_d  = '0;
      upper_d = (in_opcode_i == i2arc_pkg::OPC_HEX_UPPER) ||
                (in_opcode_i == i2arc_pkg::OPC_PTR_UPPER);
      ptr_d   = (in_opcode_i == i2arc_pkg::OPC_PTR_LOWER) ||
                (in_opcode_i == i2arc_pkg::OPC_PTR_UPPER);
      bin_d   = in_value_i;
      unique case (in_opcode_i)
        i2arc_pkg::OPC_BIN: begin
          radix_d = i2arc_pkg::RADIX_BIN;
          sh_d    = {in_value_i, 16'h0000};
          cnt_d   = i2arc_pkg::BIN_DIGITS;
        end
        i2arc_pkg::OPC_OCT: begin
          radix_d = i2arc_pkg::RADIX_OCT;
          sh_d    = {2'b00, in_value_i, 14'h0000};
          cnt_d   = i2arc_pkg::OCT_DIGITS;
        end
        i2arc_pkg::OPC_HEX_LOWER, i2arc_pkg::OPC_HEX_UPPER,
        i2arc_pkg::OPC_PTR_LOWER, i2arc_pkg::OPC_PTR_UPPER: begin
          radix_d = i2arc_pkg::RADIX_HEX;
          sh_d    = {in_value_i, 16'h0000};
          cnt_d   = i2arc_pkg::HEX_DIGITS;
        end
        default: begin
          radix_d = i2arc_pkg::RADIX_DEC;
          sh_d    = '0;
          cnt_d   = i2arc_pkg::DEC_DIGITS;
        end
      endcase
    end else if (cmd_i.conv) begin
      {sh_d, bin_d} = dabble;
      step_d        = step_q + 4'd1;
    end else if (cmd_i.shift) begin
      cnt_d = cnt_q - ONE_DIGIT;
      unique case (radix_q)
        i2arc_pkg::RADIX_BIN: sh_d = sh_q << 1;
        i2arc_pkg::RADIX_OCT: sh_d = sh_q << 3;
        default:              sh_d = sh_q << 4;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.sel)
      i2arc_pkg::CHAR_ZERO: out_char_d = ASCII_ZERO;
      i2arc_pkg::CHAR_X:    out_char_d = upper_q ? ASCII_UPPER_X : ASCII_LOWER_X;
      default:              out_char_d = digit_char;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      step_q      <= '0;
      radix_q     <= i2arc_pkg::RADIX_DEC;
      upper_q     <= 1'b0;
      ptr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      radix_q <= radix_d;
      upper_q <= upper_d;
      ptr_q   <= ptr_d;
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    bin_q <= bin_d;
    if (cmd_i.push) begin
      out_char_q <= out_char_d;
      out_last_q <= cmd_i.last;
    end
  end

  assign status_o.conv_done = (step_q == LAST_STEP);
  assign status_o.top_zero  = (digit == 4'd0);
  assign status_o.above_min = ptr_q ? (cnt_q > PTR_MIN) : (cnt_q > ONE_DIGIT);
  assign status_o.cnt_one   = (cnt_q == ONE_DIGIT);
  assign status_o.is_dec    = (radix_q == i2arc_pkg::RADIX_DEC);
  assign status_o.is_ptr    = ptr_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

`include "integer_to_ascii_radix_converter_assert.svh"

  `I2ARC_ASSERT_SAME(a_push_room, clk_i, rst_ni, cmd_i.push, !out_valid_q || out_ready_i, "push into occupied output register")
  `I2ARC_ASSERT_SAME(a_shift_count, clk_i, rst_ni, cmd_i.shift, cnt_q != '0, "digit shift with no digits left")
  `I2ARC_ASSERT_SAME(a_load_idle, clk_i, rst_ni, cmd_i.load, cnt_q == '0, "new item loaded before text finished")
  `I2ARC_ASSERT_NEXT(a_last_empties, clk_i, rst_ni, cmd_i.push && cmd_i.last, cnt_q == '0, "digits left after last character")

endmodule

>>> hdl/i2arc_ctrl.sv
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter controller
// Sequences load, conversion, leading zero skip, prefix and digit output.
// ----------------------------------------------------------------------------
module i2arc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  i2arc_pkg::dp_status_t  status_i,
  output i2arc_pkg::dp_cmd_t     cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CONV = 6'b000010,
    ST_SKIP = 6'b000100,
    ST_PFX0 = 6'b001000,
    ST_PFX1 = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, conv: 1'b0, shift: 1'b0, push: 1'b0,
                   sel: i2arc_pkg::CHAR_DIGIT, last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.conv = status_i.is_dec;
        if (!status_i.is_dec || status_i.conv_done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (status_i.top_zero && status_i.above_min) begin
          cmd_o.shift = 1'b1;
        end else begin
          state_d = status_i.is_ptr ? ST_PFX0 : ST_EMIT;
        end
      end
      ST_PFX0: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = i2arc_pkg::CHAR_ZERO;
          state_d    = ST_PFX1;
        end
      end
      ST_PFX1: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.sel  = i2arc_pkg::CHAR_X;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.push  = 1'b1;
          cmd_o.shift = 1'b1;
          cmd_o.last  = status_i.cnt_one;
          if (status_i.cnt_one) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Integer to ASCII radix converter testbench
// Sends values with every format code, from fixed corner values and from
// random values of varied length. A scoreboard builds the expected text for
// each accepted item and compares every output character and its last flag
// in order. The sender pauses between bursts, and the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [i2arc_pkg::OPCODE_W-1:0] OPC_SPARE = 3'd7;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_A_LO = 8'h61;
  localparam logic [7:0] ASCII_A_UP = 8'h41;
  localparam logic [7:0] ASCII_X_LO = 8'h78;
  localparam logic [7:0] ASCII_X_UP = 8'h58;
  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 100;

  typedef enum int {RX_FREE, RX_COIN, RX_COMB, RX_SLOW} rx_mode_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  class text_scoreboard;
    text_char_t text_q[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void note_item(logic [i2arc_pkg::VALUE_W-1:0] v,
                            logic [i2arc_pkg::OPCODE_W-1:0] op);
      logic [7:0] digits[$];
      logic [63:0] d;
      int shift;
      int pad;
      logic upper;
      logic ptr;
      text_char_t c;
      upper = (op == i2arc_pkg::OPC_HEX_UPPER) || (op == i2arc_pkg::OPC_PTR_UPPER);
      ptr = (op == i2arc_pkg::OPC_PTR_LOWER) || (op == i2arc_pkg::OPC_PTR_UPPER);
      case (op)
        i2arc_pkg::OPC_BIN: shift = 1;
        i2arc_pkg::OPC_OCT: shift = 3;
        i2arc_pkg::OPC_HEX_LOWER, i2arc_pkg::OPC_HEX_UPPER,
        i2arc_pkg::OPC_PTR_LOWER, i2arc_pkg::OPC_PTR_UPPER: shift = 4;
        default: shift = 0;
      endcase
      do begin
        if (shift == 0) begin
          d = v % 10;
          v = v / 10;
        end else begin
          d = v & ((64'd1 << shift) - 64'd1);
          v = v >> shift;
        end
        if (d < 10) begin
          digits.push_front(ASCII_ZERO + d[7:0]);
        end else begin
          digits.push_front((upper ? ASCII_A_UP : ASCII_A_LO) + d[7:0] - 8'd10);
        end
      end while (v != 0);
      if (ptr) begin
        pad = (i2arc_pkg::POINTER_MIN_DIGITS > 62) ? 62 : i2arc_pkg::POINTER_MIN_DIGITS;
        while (digits.size() < pad) digits.push_front(ASCII_ZERO);
        digits.push_front(upper ? ASCII_X_UP : ASCII_X_LO);
        digits.push_front(ASCII_ZERO);
      end
      foreach (digits[i]) begin
        c.ch = digits[i];
        c.last = (i == digits.size() - 1);
        text_q.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_char_t e;
      if (text_q.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, ch, last);
        errors++;
        return;
      end
      e = text_q.pop_front();
      if (ch !== e.ch) begin
        $display("%0t: character expected %h actual %h", $time, e.ch, ch);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t: last expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return text_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic s_valid;
  logic s_ready;
  logic [i2arc_pkg::IN_DATA_W-1:0] s_data;
  logic m_valid;
  logic m_ready;
  logic [i2arc_pkg::CHAR_W-1:0] m_data;
  logic m_last;

  text_scoreboard sb = new();
  int burst_left = 0;
  int rx_left = 0;
  rx_mode_e rx_mode = RX_FREE;
  int rx_tick = 0;

  integer_to_ascii_radix_converter uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tlast (m_last)
  );

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    s_valid = 1'b0;
    s_data = '0;
    m_ready = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_FREE: m_ready <= 1'b1;
      RX_COIN: m_ready <= $urandom_range(0, 1);
      RX_COMB: m_ready <= (rx_tick % 5) != 4;
      default: m_ready <= $urandom_range(0, 7) == 0;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && m_valid && m_ready) sb.check_char(m_data, m_last);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: errors");
    $finish;
  end

  task automatic send_item(input logic [i2arc_pkg::VALUE_W-1:0] v,
                           input logic [i2arc_pkg::OPCODE_W-1:0] op);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        s_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    s_data <= {{(i2arc_pkg::IN_DATA_W - i2arc_pkg::VALUE_W - i2arc_pkg::OPCODE_W){1'b0}},
               op, v};
    s_valid <= 1'b1;
    do @(posedge clk); while (!s_ready);
    sb.note_item(v, op);
    burst_left--;
    @(negedge clk);
  endtask

  function automatic logic [i2arc_pkg::VALUE_W-1:0] random_value();
    logic [i2arc_pkg::VALUE_W-1:0] v;
    logic [i2arc_pkg::VALUE_W-1:0] p;
    int k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: ;
      1: begin
        p = 64'd1;
        k = $urandom_range(0, 19);
        repeat (k) p = p * 10;
        v = $urandom_range(0, 1) ? p : p - 64'd1;
      end
      2: begin
        p = 64'd1 << $urandom_range(0, 63);
        v = $urandom_range(0, 1) ? p : p - 64'd1;
      end
      default: v = v >> $urandom_range(0, 63);
    endcase
    return v;
  endfunction

  initial begin
    logic [i2arc_pkg::OPCODE_W-1:0] all_ops[8];
    all_ops = '{i2arc_pkg::OPC_DEC, i2arc_pkg::OPC_BIN, i2arc_pkg::OPC_OCT,
                i2arc_pkg::OPC_HEX_LOWER, i2arc_pkg::OPC_HEX_UPPER,
                i2arc_pkg::OPC_PTR_LOWER, i2arc_pkg::OPC_PTR_UPPER, OPC_SPARE};
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (all_ops[i]) send_item(64'd0, all_ops[i]);
    foreach (all_ops[i]) send_item({i2arc_pkg::VALUE_W{1'b1}}, all_ops[i]);
    send_item(64'hFFFF_FFFF_FFFF, i2arc_pkg::OPC_PTR_LOWER);
    send_item(64'h1_0000_0000_0000, i2arc_pkg::OPC_PTR_UPPER);
    send_item(64'hDEAD_BEEF, i2arc_pkg::OPC_PTR_UPPER);
    send_item(64'd10000000000000000000, i2arc_pkg::OPC_DEC);
    send_item(64'd9999999999999999999, i2arc_pkg::OPC_DEC);
    send_item(64'h00AB_CDEF, i2arc_pkg::OPC_HEX_LOWER);
    send_item(64'd1, i2arc_pkg::OPC_BIN);

    repeat (RANDOM_ITEMS) begin
      send_item(random_value(), 3'($urandom_range(0, 7)));
    end
    s_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
